/* design/sbsf_pkg.sv */
// Shared types, constants and register codes of the static box suppression filter.
`default_nettype none

package sbsf_pkg;

    localparam int DEF_CHANNELS    = 16;
    localparam int DEF_RING_DEPTH  = 50;
    localparam int DEF_COORD_SCALE = 1000;

    localparam int CH_W       = 4;
    localparam int TIME_W     = 32;
    localparam int COORD_W    = 10;
    localparam int HELD_W     = 6;
    localparam int SENS_W     = 2;
    localparam int EXPIRY_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPIRY      = 2'd1;

    // Sensitivity codes and the divisor each one selects.
    localparam logic [SENS_W-1:0] SENS_DIV5    = 2'd0;
    localparam logic [SENS_W-1:0] SENS_DIV10   = 2'd1;
    localparam logic [SENS_W-1:0] SENS_DIV20   = 2'd2;
    localparam logic [SENS_W-1:0] SENS_DIV10_B = 2'd3;

    localparam logic [SENS_W-1:0]   SENS_RESET   = SENS_DIV10;
    localparam logic [EXPIRY_W-1:0] EXPIRY_RESET = 16'd65;

    typedef struct packed {
        logic [COORD_W-1:0] left_x;
        logic [COORD_W-1:0] top_y;
        logic [COORD_W-1:0] right_x;
        logic [COORD_W-1:0] bottom_y;
    } t_corners;

    typedef struct packed {
        logic [CH_W-1:0]    channel;
        logic [TIME_W-1:0]  event_time;
        logic [COORD_W-1:0] left_x;
        logic [COORD_W-1:0] top_y;
        logic [COORD_W-1:0] right_x;
        logic [COORD_W-1:0] bottom_y;
    } t_in_item;

    typedef struct packed {
        logic              suppressed;
        logic [HELD_W-1:0] entries_held;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] wr_data;
    } t_cfg_write;

endpackage

`default_nettype wire

/* design/sbsf_ifs.sv */
// Valid/ready channel interfaces for the input, result and configuration beats.
`default_nettype none

interface sbsf_in_if
    import sbsf_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sbsf_out_if
    import sbsf_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sbsf_cfg_if
    import sbsf_pkg::*;
();
    logic       valid;
    logic       ready;
    t_cfg_write data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/sbsf_match.sv */
// Corner proximity test of one held box against the new box.
`default_nettype none

module sbsf_match
    import sbsf_pkg::*;
(
    input  t_corners          i_held,
    input  t_corners          i_fresh,
    input  logic [SENS_W-1:0] i_sens,
    output logic              o_match
);

    logic signed [COORD_W:0] span_x;
    logic signed [COORD_W:0] span_y;

    // |held - fresh| * div < span, with div in {5, 10, 20} built from shifts.
    function automatic logic corner_close(
        input logic [COORD_W-1:0] held,
        input logic [COORD_W-1:0] fresh,
        input logic signed [COORD_W:0] span,
        input logic [SENS_W-1:0]  sel
    );
        logic signed [COORD_W:0] diff;
        logic [COORD_W-1:0]      mag;
        logic [COORD_W+5:0]      scaled;
        diff = $signed({1'b0, held}) - $signed({1'b0, fresh});
        mag  = diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];
        case (sel)
            SENS_DIV5:  scaled = ((COORD_W+6)'(mag) << 2) + (COORD_W+6)'(mag);
            SENS_DIV20: scaled = ((COORD_W+6)'(mag) << 4) + ((COORD_W+6)'(mag) << 2);
            default:    scaled = ((COORD_W+6)'(mag) << 3) + ((COORD_W+6)'(mag) << 1);
        endcase
        return !span[COORD_W] && (scaled < (COORD_W+6)'(span[COORD_W-1:0]));
    endfunction

    assign span_x = $signed({1'b0, i_held.right_x}) - $signed({1'b0, i_held.left_x});
    assign span_y = $signed({1'b0, i_held.bottom_y}) - $signed({1'b0, i_held.top_y});

    assign o_match = corner_close(i_held.left_x,   i_fresh.left_x,   span_x, i_sens)
                  && corner_close(i_held.top_y,    i_fresh.top_y,    span_y, i_sens)
                  && corner_close(i_held.right_x,  i_fresh.right_x,  span_x, i_sens)
                  && corner_close(i_held.bottom_y, i_fresh.bottom_y, span_y, i_sens);

endmodule

`default_nettype wire

/* design/static_box_suppression_filter.sv */
// Top level of the static box suppression filter: ring control, held-box memories, result.
//
// Usage. Detected boxes arrive as beats on i_in (channel, time, four corners).
// For each accepted beat exactly one result beat leaves on o_out: whether the
// box matched a box already held for its channel, and how many boxes that
// channel holds after the new box was appended. i_cfg writes the sensitivity
// (index 0) and the expiry time in seconds (index 1); it is always ready and
// is only to be written while no item is in flight.
// Flow. One item at a time is in work; the block takes no new beat before the
// last one has left its final step. An item passes the expiry walk, which drops
// expired boxes from the ring head, then the trim, then the compare walk over the
// boxes then held. The held-box memories have one read port each, so the expiry
// walk reads, then checks, each head box in turn, while the compare walk checks
// each box as the read of the next one goes out. A match ends the walk early.
// Reset. The synchronous reset empties every ring and loads the default
// sensitivity and expiry. The memories themselves are not cleared: only
// entries inside a ring's fill are ever read.
// Stalls. The result sits in an output register. The next item is accepted
// while it waits; that item then holds in its final step until o_out drains.
`default_nettype none

module static_box_suppression_filter
    import sbsf_pkg::*;
#(
    parameter int CHANNELS    = DEF_CHANNELS,
    parameter int RING_DEPTH  = DEF_RING_DEPTH,
    parameter int COORD_SCALE = DEF_COORD_SCALE
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    sbsf_in_if.sink     i_in,
    sbsf_out_if.source  o_out,
    sbsf_cfg_if.sink    i_cfg
);

    localparam int SLOTS = CHANNELS * RING_DEPTH;
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FW    = $clog2(RING_DEPTH + 1);
    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_EXP_RD  = 6'b000010,
        S_EXP_CHK = 6'b000100,
        S_TRIM    = 6'b001000,
        S_SCAN    = 6'b010000,
        S_APPEND  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // Item being worked on.
    logic [CW-1:0]     r_ch;
    logic [AW-1:0]     r_base;
    logic [TIME_W-1:0] r_now;
    t_corners          r_fresh;
    logic              r_skip, n_skip;

    // Working copy of the channel's ring pointers and the compare walk.
    logic [PW-1:0] r_start, n_start;
    logic [FW-1:0] r_fill,  n_fill;
    logic [PW-1:0] r_ptr,   n_ptr;
    logic [FW-1:0] r_idx,   n_idx;
    logic          r_pend,  n_pend;
    logic          r_hit,   n_hit;

    // Configuration.
    logic [SENS_W-1:0]   r_sens;
    logic [EXPIRY_W-1:0] r_expiry;

    // Per-channel ring head and fill.
    logic [PW-1:0] r_ring_start [CHANNELS];
    logic [FW-1:0] r_ring_fill  [CHANNELS];

    // Held-box memories and their registered read data.
    logic [TIME_W-1:0] r_mem_time [SLOTS];
    t_corners          r_mem_corn [SLOTS];
    logic [TIME_W-1:0] r_time_q;
    t_corners          r_corn_q;

    // Output register.
    logic      r_out_vld, n_out_vld;
    t_out_item r_out_data, n_out_data;

    logic          in_beat;
    logic          ch_ok;
    logic [CW-1:0] in_ch;
    logic          expired;
    logic          match;
    logic          out_free;
    logic          append_go;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [PW:0]   app_sum;
    logic [PW:0]   app_wrap;
    logic [AW-1:0] wr_addr;
    logic [6:0]    held_next;

    function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
        if (13'(v) > 13'(COORD_SCALE)) begin
            return COORD_W'(COORD_SCALE);
        end
        return v;
    endfunction

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        if (p == PW'(RING_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign in_beat     = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_ch       = i_in.data.channel[CW-1:0];
    assign ch_ok       = ({1'b0, i_in.data.channel} < 5'(CHANNELS));

    // A head box is expired when now > held_time + expiry, summed without wrap.
    assign expired = {1'b0, r_now} > ({1'b0, r_time_q} + 33'(r_expiry));

    sbsf_match u_match (
        .i_held  (r_corn_q),
        .i_fresh (r_fresh),
        .i_sens  (r_sens),
        .o_match (match)
    );

    // The result register must be free (or draining) before the item retires.
    assign out_free  = !r_out_vld || o_out.ready;
    assign append_go = (r_state == S_APPEND) && out_free;

    // One read port serves both walks: the ring head during expiry, the
    // running pointer during the compare walk.
    assign rd_en   = ((r_state == S_EXP_RD) && (r_fill != '0))
                  || ((r_state == S_SCAN) && (r_idx != r_fill) && !(r_pend && match));
    assign rd_addr = r_base + AW'((r_state == S_EXP_RD) ? r_start : r_ptr);

    // The new box goes behind the last held box, modulo the ring depth.
    assign app_sum   = (PW+1)'(r_start) + (PW+1)'(r_fill);
    assign app_wrap  = (app_sum >= (PW+1)'(RING_DEPTH)) ? app_sum - (PW+1)'(RING_DEPTH)
                                                        : app_sum;
    assign wr_addr   = r_base + AW'(app_wrap[PW-1:0]);
    assign held_next = 7'(r_fill) + 7'd1;

    always_comb begin
        n_state    = r_state;
        n_start    = r_start;
        n_fill     = r_fill;
        n_ptr      = r_ptr;
        n_idx      = r_idx;
        n_pend     = 1'b0;
        n_hit      = r_hit;
        n_skip     = r_skip;
        n_out_vld  = r_out_vld;
        n_out_data = r_out_data;

        if (r_out_vld && o_out.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_hit  = 1'b0;
                    n_skip = !ch_ok;
                    if (ch_ok) begin
                        n_start = r_ring_start[in_ch];
                        n_fill  = r_ring_fill[in_ch];
                        n_state = S_EXP_RD;
                    end else begin
                        // Out-of-range channel: no state change, empty result.
                        n_start = '0;
                        n_fill  = '0;
                        n_state = S_APPEND;
                    end
                end
            end
            S_EXP_RD: begin
                n_state = (r_fill == '0) ? S_TRIM : S_EXP_CHK;
            end
            S_EXP_CHK: begin
                if (expired) begin
                    n_start = ptr_inc(r_start);
                    n_fill  = r_fill - 1'b1;
                    n_state = S_EXP_RD;
                end else begin
                    n_state = S_TRIM;
                end
            end
            S_TRIM: begin
                n_ptr = r_start;
                if (r_fill >= FW'(RING_DEPTH)) begin
                    n_start = ptr_inc(r_start);
                    n_fill  = FW'(RING_DEPTH - 1);
                    n_ptr   = ptr_inc(r_start);
                end
                n_idx   = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                n_pend = rd_en;
                if (rd_en) begin
                    n_ptr = ptr_inc(r_ptr);
                    n_idx = r_idx + 1'b1;
                end
                if (r_pend && match) begin
                    n_hit   = 1'b1;
                    n_state = S_APPEND;
                end else if (r_idx == r_fill) begin
                    n_state = S_APPEND;
                end
            end
            S_APPEND: begin
                if (out_free) begin
                    n_out_vld                  = 1'b1;
                    n_out_data.suppressed      = r_hit && !r_skip;
                    n_out_data.entries_held    = r_skip ? '0 : held_next[HELD_W-1:0];
                    n_state                    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_start   <= '0;
            r_fill    <= '0;
            r_ptr     <= '0;
            r_idx     <= '0;
            r_pend    <= 1'b0;
            r_hit     <= 1'b0;
            r_skip    <= 1'b0;
            r_out_vld <= 1'b0;
            r_sens    <= SENS_RESET;
            r_expiry  <= EXPIRY_RESET;
            for (int c = 0; c < CHANNELS; c++) begin
                r_ring_start[c] <= '0;
                r_ring_fill[c]  <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_start   <= n_start;
            r_fill    <= n_fill;
            r_ptr     <= n_ptr;
            r_idx     <= n_idx;
            r_pend    <= n_pend;
            r_hit     <= n_hit;
            r_skip    <= n_skip;
            r_out_vld <= n_out_vld;
            if (i_cfg.valid) begin
                case (i_cfg.data.reg_index)
                    REG_SENSITIVITY: r_sens   <= i_cfg.data.wr_data[SENS_W-1:0];
                    REG_EXPIRY:      r_expiry <= i_cfg.data.wr_data;
                    default: ;
                endcase
            end
            if (append_go && !r_skip) begin
                r_ring_start[r_ch] <= r_start;
                r_ring_fill[r_ch]  <= held_next[FW-1:0];
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        if (in_beat) begin
            r_ch             <= in_ch;
            r_base           <= AW'(32'(i_in.data.channel) * RING_DEPTH);
            r_now            <= i_in.data.event_time;
            r_fresh.left_x   <= clamp_coord(i_in.data.left_x);
            r_fresh.top_y    <= clamp_coord(i_in.data.top_y);
            r_fresh.right_x  <= clamp_coord(i_in.data.right_x);
            r_fresh.bottom_y <= clamp_coord(i_in.data.bottom_y);
        end
    end

    // Held-box memories: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (append_go && !r_skip) begin
            r_mem_time[wr_addr] <= r_now;
            r_mem_corn[wr_addr] <= r_fresh;
        end
        if (rd_en) begin
            r_time_q <= r_mem_time[rd_addr];
            r_corn_q <= r_mem_corn[rd_addr];
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out_data;

    // An out-of-range channel goes straight to the retire step.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && !ch_ok) |=> (r_state == S_APPEND && r_skip))
        else $error("out-of-range channel did not bypass the ring walk");

    // The compare walk never sees a full ring, so the append cannot overwrite.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_APPEND) |-> (r_fill < FW'(RING_DEPTH) || r_skip))
        else $error("ring still full after trim");

    // A match is only recorded at the end of the compare walk.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_hit) |-> ($past(r_state) == S_SCAN && r_state == S_APPEND))
        else $error("match flagged outside the compare walk");

    // No compare is in flight once the block is back to idle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend)
        else $error("compare pending while idle");

    // Retiring an item always leaves a result in the output register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        append_go |=> r_out_vld)
        else $error("retired item produced no result beat");

endmodule

`default_nettype wire
